>>> design/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants shared by the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int ARENA_BYTES = 16384;
  localparam int HDR_BYTES   = 24;
  localparam int MAX_BLOCKS  = 64;
  localparam int OFF_W       = 14;
  localparam int SLOT_W      = $clog2(MAX_BLOCKS);

  typedef struct packed {
    logic        kind;
    logic [15:0] req_size;
    logic [15:0] free_addr;
  } ffba_in_t;

  typedef struct packed {
    logic             ok;
    logic [OFF_W-1:0] addr;
  } ffba_out_t;

  typedef struct packed {
    logic [OFF_W-1:0]  off;
    logic [OFF_W-1:0]  size;
    logic [SLOT_W-1:0] link;
  } ffba_ent_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ARD,
    S_ACHK,
    S_SCAN,
    S_SPL1,
    S_SPL2,
    S_FRD,
    S_FCHK,
    S_MRD,
    S_MCHK,
    S_MRD2,
    S_MCHK2,
    S_FIN
  } state_e;

  localparam logic              KIND_ALLOC = 1'b0;
  localparam logic [OFF_W-1:0]  HDR14      = OFF_W'(HDR_BYTES);
  localparam logic [OFF_W-1:0]  SIZE0      = OFF_W'(ARENA_BYTES - HDR_BYTES);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(MAX_BLOCKS - 1);

endpackage

>>> design/first_fit_block_allocator.sv
// An alloc walks the block list, and on a split scans for a spare slot and then
// writes two entries; a free walks the list, then merges free neighbours and
// reloads after each merge. One item in flight; stall held meanwhile.
// Reset leaves only slot 0 used and free: one free block spans the arena.
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator with block split and free-block coalescing.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
  import ffba_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ffba_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ffba_out_t out_item_o
);

  state_e state_q, state_d;

  logic [MAX_BLOCKS-1:0] free_q, free_d;
  logic [MAX_BLOCKS-1:0] hlink_q, hlink_d;
  logic [MAX_BLOCKS-1:0] used_q, used_d;
  logic [MAX_BLOCKS-1:0] wr_q, wr_d;

  logic [SLOT_W-1:0] cur_q, cur_d;
  logic [SLOT_W-1:0] nx_q, nx_d;
  logic [SLOT_W-1:0] ns_q, ns_d;
  ffba_ent_t         ent_q, ent_d;
  logic [15:0]       req_q, req_d;
  logic [15:0]       fa_q, fa_d;
  logic              res_ok_q, res_ok_d;
  logic [OFF_W-1:0]  res_addr_q, res_addr_d;
  logic              out_valid_q, out_valid_d;
  ffba_out_t         out_item_q, out_item_d;

  ffba_ent_t         mem [MAX_BLOCKS];
  ffba_ent_t         rdata_q;
  logic              rd_wr_q;
  logic              rd_zero_q;
  logic [SLOT_W-1:0] raddr;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  ffba_ent_t         mem_wdata;
  ffba_ent_t         rd_ent;

  logic              in_acc;
  logic              c_fit, c_exact, c_split, c_match, c_both, c_load;
  logic [OFF_W-1:0]  merge_size;

  assign in_acc = in_valid_i && (state_q == S_IDLE);
  assign raddr  = (state_q == S_MRD2) ? nx_q : cur_q;

  always_comb begin
    if (rd_wr_q) begin
      rd_ent = rdata_q;
    end else begin
      rd_ent.off  = '0;
      rd_ent.size = rd_zero_q ? SIZE0 : '0;
      rd_ent.link = '0;
    end
  end

  assign c_fit   = free_q[cur_q] && ({3'b0, rd_ent.size} >= {1'b0, req_q});
  assign c_exact = ({2'b0, rd_ent.size} == req_q);
  assign c_split = ({3'b0, rd_ent.size} > ({1'b0, req_q} + 17'(HDR_BYTES)));
  assign c_match = (({2'b0, rd_ent.off} + 16'(HDR_BYTES)) == fa_q);
  assign c_both  = free_q[cur_q] && free_q[nx_q];
  assign c_load  = !out_valid_q || !out_stall_i;
  assign merge_size = ent_q.size + rd_ent.size + HDR14;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.kind == KIND_ALLOC) begin
            state_d = S_ARD;
          end else if ({1'b0, in_item_i.free_addr} >= 17'(ARENA_BYTES)) begin
            state_d = S_FIN;
          end else begin
            state_d = S_FRD;
          end
        end
      end
      S_ARD:  state_d = S_ACHK;
      S_ACHK: begin
        if (c_fit) begin
          if (c_exact) state_d = S_FIN;
          else if (c_split) state_d = S_SCAN;
          else state_d = S_FIN;
        end else if (hlink_q[cur_q]) begin
          state_d = S_ARD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SCAN: begin
        if (!used_q[ns_q]) state_d = S_SPL1;
        else if (ns_q == LAST_SLOT) state_d = S_FIN;
      end
      S_SPL1: state_d = S_SPL2;
      S_SPL2: state_d = S_FIN;
      S_FRD:  state_d = S_FCHK;
      S_FCHK: begin
        if (c_match) state_d = S_MRD;
        else if (hlink_q[cur_q]) state_d = S_FRD;
        else state_d = S_FIN;
      end
      S_MRD:  state_d = S_MCHK;
      S_MCHK: state_d = hlink_q[cur_q] ? S_MRD2 : S_FIN;
      S_MRD2: state_d = S_MCHK2;
      S_MCHK2: begin
        if (!hlink_q[nx_q]) state_d = S_FIN;
        else if (c_both) state_d = S_MRD;
        else state_d = S_MRD2;
      end
      S_FIN:  if (c_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    free_d      = free_q;
    hlink_d     = hlink_q;
    used_d      = used_q;
    wr_d        = wr_q;
    cur_d       = cur_q;
    nx_d        = nx_q;
    ns_d        = ns_q;
    ent_d       = ent_q;
    req_d       = req_q;
    fa_d        = fa_q;
    res_ok_d    = res_ok_q;
    res_addr_d  = res_addr_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    mem_we      = 1'b0;
    mem_waddr   = cur_q;
    mem_wdata   = ent_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cur_d      = '0;
          req_d      = in_item_i.req_size;
          fa_d       = in_item_i.free_addr;
          res_ok_d   = 1'b0;
          res_addr_d = '0;
        end
      end
      S_ACHK: begin
        ent_d = rd_ent;
        ns_d  = '0;
        if (c_fit) begin
          if (c_exact) begin
            free_d[cur_q] = 1'b0;
            res_ok_d      = 1'b1;
            res_addr_d    = rd_ent.off + HDR14;
          end
        end else begin
          cur_d = rd_ent.link;
        end
      end
      S_SCAN: begin
        if (used_q[ns_q]) ns_d = ns_q + 1'b1;
      end
      S_SPL1: begin
        mem_we         = 1'b1;
        mem_waddr      = ns_q;
        mem_wdata.off  = ent_q.off + HDR14 + req_q[OFF_W-1:0];
        mem_wdata.size = ent_q.size - req_q[OFF_W-1:0] - HDR14;
        mem_wdata.link = ent_q.link;
        used_d[ns_q]   = 1'b1;
        free_d[ns_q]   = 1'b1;
        hlink_d[ns_q]  = hlink_q[cur_q];
        wr_d[ns_q]     = 1'b1;
      end
      S_SPL2: begin
        mem_we         = 1'b1;
        mem_waddr      = cur_q;
        mem_wdata.off  = ent_q.off;
        mem_wdata.size = req_q[OFF_W-1:0];
        mem_wdata.link = ns_q;
        free_d[cur_q]  = 1'b0;
        hlink_d[cur_q] = 1'b1;
        wr_d[cur_q]    = 1'b1;
        res_ok_d       = 1'b1;
        res_addr_d     = ent_q.off + HDR14;
      end
      S_FCHK: begin
        if (c_match) begin
          free_d[cur_q] = 1'b1;
          res_ok_d      = 1'b1;
          cur_d         = '0;
        end else begin
          cur_d = rd_ent.link;
        end
      end
      S_MCHK: begin
        ent_d = rd_ent;
        nx_d  = rd_ent.link;
      end
      S_MCHK2: begin
        nx_d = rd_ent.link;
        if (c_both) begin
          mem_we         = 1'b1;
          mem_waddr      = cur_q;
          mem_wdata.off  = ent_q.off;
          mem_wdata.size = merge_size;
          mem_wdata.link = rd_ent.link;
          wr_d[cur_q]    = 1'b1;
          ent_d.size     = merge_size;
          ent_d.link     = rd_ent.link;
          hlink_d[cur_q] = hlink_q[nx_q];
          used_d[nx_q]   = 1'b0;
          hlink_d[nx_q]  = 1'b0;
          cur_d          = rd_ent.link;
        end else begin
          cur_d = nx_q;
          ent_d = rd_ent;
        end
      end
      S_FIN: begin
        if (c_load) begin
          out_valid_d     = 1'b1;
          out_item_d.ok   = res_ok_q;
          out_item_d.addr = res_ok_q ? res_addr_q : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q   <= mem[raddr];
    rd_wr_q   <= wr_q[raddr];
    rd_zero_q <= (raddr == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_q      <= MAX_BLOCKS'(1);
      hlink_q     <= '0;
      used_q      <= MAX_BLOCKS'(1);
      wr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_q      <= free_d;
      hlink_q     <= hlink_d;
      used_q      <= used_d;
      wr_q        <= wr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    nx_q       <= nx_d;
    ns_q       <= ns_d;
    ent_q      <= ent_d;
    req_q      <= req_d;
    fa_q       <= fa_d;
    res_ok_q   <= res_ok_d;
    res_addr_q <= res_addr_d;
    out_item_q <= out_item_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTH
  a_head_used: assert property (@(posedge clk_i) disable iff (!rst_ni) used_q[0])
    else $error("head slot released");
  a_link_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hlink_q & ~used_q) == '0)
    else $error("link on unused slot");
  a_fail_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.ok |-> out_item_o.addr == '0)
    else $error("failed item carries an address");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != S_IDLE)
    else $error("accepted item not processed");
`endif

endmodule
